FILE: hdl/modexp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package modexp_pkg;

   // Operand bits taken from base and exponent (sign bit at OPERAND_BITS-1)
   localparam int OPERAND_BITS = 32;
   // Modulus and residue width
   localparam int RES_BITS     = 31;
   // Multiplier operand width of the shared unit: covers a residue and a magnitude
   localparam int B_BITS       = (OPERAND_BITS > RES_BITS) ? OPERAND_BITS : RES_BITS;
   localparam int CNT_BITS     = $clog2(B_BITS);

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BASE,
      ST_BASE_WAIT,
      ST_STEP,
      ST_MUL_WAIT,
      ST_SQR_WAIT,
      ST_DONE
   } state_type;

   // Request to the modular multiplier
   typedef struct packed {
      logic                start;
      logic [RES_BITS-1:0] a;
      logic [B_BITS-1:0]   b;
      logic [RES_BITS-1:0] m;
   } mm_req_type;

   // Response from the modular multiplier
   typedef struct packed {
      logic                done;
      logic [RES_BITS-1:0] product;
   } mm_rsp_type;

endpackage

`default_nettype wire

FILE: hdl/modexp_mulmod.sv
`timescale 1ns / 1ps
`default_nettype none

// Interleaved shift-and-add multiply with reduction: (a * b) mod m,
// one multiplier bit per cycle. Needs a < m and m >= 2.
module modexp_mulmod
   import modexp_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   input  mm_req_type req,
   output mm_rsp_type rsp
);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [RES_BITS-1:0] r_ff, r_in;
   logic [RES_BITS-1:0] a_ff, a_in;
   logic [B_BITS-1:0]   b_ff, b_in;
   logic [RES_BITS-1:0] m_ff, m_in;

   logic [RES_BITS+1:0] sum;
   logic [RES_BITS+1:0] m1_ext;
   logic [RES_BITS+1:0] m2_ext;
   logic [RES_BITS+1:0] reduced;

   // One step: r = (2r + bit*a) mod m, sum stays below 3m
   always_comb begin
      sum    = {1'b0, r_ff, 1'b0} + (b_ff[B_BITS-1] ? {2'b00, a_ff} : '0);
      m1_ext = {2'b00, m_ff};
      m2_ext = {1'b0, m_ff, 1'b0};
      if (sum >= m2_ext) begin
         reduced = sum - m2_ext;
      end else if (sum >= m1_ext) begin
         reduced = sum - m1_ext;
      end else begin
         reduced = sum;
      end
   end

   // Sequencing of the bit steps
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      r_in    = r_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      m_in    = m_ff;
      if (busy_ff) begin
         r_in   = reduced[RES_BITS-1:0];
         b_in   = {b_ff[B_BITS-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(B_BITS - 1);
         r_in    = '0;
         a_in    = req.a;
         b_in    = req.b;
         m_in    = req.m;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      r_ff   <= r_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      m_ff   <= m_in;
   end

   assign rsp.done    = done_ff;
   assign rsp.product = r_ff;

endmodule

`default_nettype wire

FILE: hdl/modular_exponentiation_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Modular exponentiation core: residue = base_value ^ exponent mod modulus, by
// right-to-left square-and-multiply. One transaction is worked at a time; the
// input is not ready while it runs. All multiplications, including the base
// reduction, go through one shared modular multiplier that handles one
// multiplier bit per cycle. A squaring that directly follows a multiply is
// started from the multiply wait; any other squaring or multiply is started
// from the step state. The base is first reduced with one pass of that unit,
// then each exponent bit up to the highest set one costs one squaring plus one
// multiply when the bit is set; the squaring after the highest set bit is
// skipped. A modulus of 0 or 1 gives 0 without using the multiplier; an
// exponent of zero or below gives 1. The result is held in an output register,
// and a new transaction is taken while it waits to be read.
module modular_exponentiation_core
   import modexp_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   // req_tdata: [31:0] base_value, [63:32] exponent, [94:64] modulus, [95] zero
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [95:0] req_tdata,
   // rsp_tdata: [30:0] residue, [31] zero
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [31:0] rsp_tdata
);

   state_type           state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RES_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic [RES_BITS-1:0] m_ff, m_in;
   logic [RES_BITS-1:0] acc_ff, acc_in;
   logic [RES_BITS-1:0] sq_ff, sq_in;
   logic [B_BITS-1:0]   mag_ff, mag_in;
   logic                neg_ff, neg_in;
   logic [OPERAND_BITS-1:0] e_ff, e_in;

   logic [OPERAND_BITS-1:0] base_raw;
   logic [OPERAND_BITS-1:0] exp_raw;
   logic [RES_BITS-1:0]     mod_in;
   logic [OPERAND_BITS-1:0] base_mag;

   mm_req_type mm_req;
   mm_rsp_type mm_rsp;

   modexp_mulmod u_mulmod (
      .clock (clock),
      .reset (reset),
      .req   (mm_req),
      .rsp   (mm_rsp)
   );

   // Field extraction
   assign base_raw = req_tdata[OPERAND_BITS-1:0];
   assign exp_raw  = req_tdata[32 +: OPERAND_BITS];
   assign mod_in   = req_tdata[64 +: RES_BITS];
   assign base_mag = base_raw[OPERAND_BITS-1] ? (~base_raw + 1'b1) : base_raw;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff};

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      m_in         = m_ff;
      acc_in       = acc_ff;
      sq_in        = sq_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      e_in         = e_ff;
      mm_req.start = 1'b0;
      mm_req.a     = sq_ff;
      mm_req.b     = B_BITS'(sq_ff);
      mm_req.m     = m_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               m_in   = mod_in;
               neg_in = base_raw[OPERAND_BITS-1];
               mag_in = B_BITS'(base_mag);
               e_in   = exp_raw[OPERAND_BITS-1] ? '0 : exp_raw;
               if (mod_in <= RES_BITS'(1)) begin
                  acc_in   = '0;
                  state_in = ST_DONE;
               end else begin
                  acc_in   = RES_BITS'(1);
                  state_in = ST_BASE;
               end
            end
         end
         ST_BASE: begin
            // base magnitude mod m, as 1 * magnitude
            mm_req.start = 1'b1;
            mm_req.a     = RES_BITS'(1);
            mm_req.b     = mag_ff;
            state_in     = ST_BASE_WAIT;
         end
         ST_BASE_WAIT: begin
            if (mm_rsp.done) begin
               if (neg_ff && (mm_rsp.product != '0)) begin
                  sq_in = m_ff - mm_rsp.product;
               end else begin
                  sq_in = mm_rsp.product;
               end
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (e_ff == '0) begin
               state_in = ST_DONE;
            end else if (e_ff[0]) begin
               mm_req.start = 1'b1;
               mm_req.a     = acc_ff;
               state_in     = ST_MUL_WAIT;
            end else begin
               mm_req.start = 1'b1;
               state_in     = ST_SQR_WAIT;
            end
         end
         ST_MUL_WAIT: begin
            if (mm_rsp.done) begin
               acc_in = mm_rsp.product;
               if (e_ff[OPERAND_BITS-1:1] == '0) begin
                  state_in = ST_DONE;
               end else begin
                  mm_req.start = 1'b1;
                  state_in     = ST_SQR_WAIT;
               end
            end
         end
         ST_SQR_WAIT: begin
            if (mm_rsp.done) begin
               sq_in    = mm_rsp.product;
               e_in     = {1'b0, e_ff[OPERAND_BITS-1:1]};
               state_in = ST_STEP;
            end
         end
         ST_DONE: begin
            // hand over once the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = acc_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      m_ff        <= m_in;
      acc_ff      <= acc_in;
      sq_ff       <= sq_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      e_ff        <= e_in;
   end

endmodule

`default_nettype wire
